// ===== rtl/nqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqc_pkg
// shared types and constants of the n-queens solution counter
// ----------------------------------------------------------------------------
package nqc_pkg;

   localparam int MAX_BOARD_DEFAULT = 16;
   localparam int SIZE_W            = 5;
   localparam int COUNT_W           = 24;
   localparam int FIELD_W           = 4;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [SIZE_W-1:0] BOARD_SIZE_RESET = SIZE_W'(8);

   // register index, taken from paddr[2]
   localparam logic REG_BOARD_SIZE = 1'b0;

   typedef struct packed {
      logic               preset_enable;
      logic [FIELD_W-1:0] preset_row;
      logic [FIELD_W-1:0] preset_col;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] solution_count;
      logic               preset_ignored;
   } rsp_type;

endpackage

// ===== rtl/n_queens_solution_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_counter
// depth-first backtracking count of non-attacking queen placements
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          beat on start && !busy
//  result    rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//  config    psel penable pwrite paddr ...  apb write, pready tied high
//
//  each row tested, each column out of rows, each board completed and each
//  column stepped back or over is a step of its own; all placement checks and
//  mask toggles go through the single shared attack-check / mask-toggle unit
//  synchronous active-high reset; board size returns to 8
//  busy stays high from the accepted request until the result strobe
//  the result strobe cannot be stalled
// ----------------------------------------------------------------------------
module n_queens_solution_counter #(
   parameter int MAX_BOARD = nqc_pkg::MAX_BOARD_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  nqc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output nqc_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [nqc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [nqc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [nqc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int ROW_W  = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
   localparam int CNT_W  = $clog2(MAX_BOARD + 1);
   localparam int DIAG_N = 2 * MAX_BOARD - 1;
   localparam int DIAG_W = (DIAG_N > 1) ? $clog2(DIAG_N) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_BACK
   } state_type;

   state_type                    state_ff, state_in;
   logic [nqc_pkg::SIZE_W-1:0]   board_size_ff;
   logic [CNT_W-1:0]             col_ff, col_in;
   logic [CNT_W-1:0]             row_ff, row_in;
   logic [MAX_BOARD-1:0]         rows_ff, rows_in;
   logic [DIAG_N-1:0]            rise_ff, rise_in;
   logic [DIAG_N-1:0]            fall_ff, fall_in;
   logic [nqc_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         have_preset_ff, have_preset_in;
   logic [nqc_pkg::FIELD_W-1:0]  preset_col_ff, preset_col_in;
   logic                         ignored_ff, ignored_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]             stack_ff [MAX_BOARD];
   logic                         stack_we;

   logic [CNT_W-1:0]             n_eff;
   logic [CNT_W-1:0]             back_col;
   logic                         preset_fits;
   logic                         at_preset_col;
   logic                         back_preset_col;

   // shared attack-check and mask-toggle unit
   logic [ROW_W-1:0]             sel_row;
   logic [ROW_W-1:0]             sel_col;
   logic [DIAG_W-1:0]            rise_idx;
   logic [DIAG_W-1:0]            fall_idx;
   logic [MAX_BOARD-1:0]         row_bit;
   logic [DIAG_N-1:0]            rise_bit;
   logic [DIAG_N-1:0]            fall_bit;
   logic                         sel_free;

   logic                         csr_write;

   assign n_eff = (board_size_ff > nqc_pkg::SIZE_W'(MAX_BOARD)) ?
                  CNT_W'(MAX_BOARD) : board_size_ff[CNT_W-1:0];
   assign back_col = col_ff - CNT_W'(1);
   assign preset_fits = (nqc_pkg::SIZE_W'(req_data.preset_row) < nqc_pkg::SIZE_W'(n_eff)) &&
                        (nqc_pkg::SIZE_W'(req_data.preset_col) < nqc_pkg::SIZE_W'(n_eff));
   assign at_preset_col = have_preset_ff &&
                          (nqc_pkg::SIZE_W'(col_ff) == nqc_pkg::SIZE_W'(preset_col_ff));
   assign back_preset_col = have_preset_ff &&
                            (nqc_pkg::SIZE_W'(back_col) == nqc_pkg::SIZE_W'(preset_col_ff));

   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            sel_row = req_data.preset_row[ROW_W-1:0];
            sel_col = req_data.preset_col[ROW_W-1:0];
         end
         ST_STEP: begin
            sel_row = row_ff[ROW_W-1:0];
            sel_col = col_ff[ROW_W-1:0];
         end
         default: begin
            sel_row = stack_ff[back_col[ROW_W-1:0]];
            sel_col = back_col[ROW_W-1:0];
         end
      endcase
   end

   assign rise_idx = DIAG_W'(sel_row) + DIAG_W'(sel_col);
   assign fall_idx = DIAG_W'(sel_row) + DIAG_W'(MAX_BOARD - 1) - DIAG_W'(sel_col);
   assign row_bit  = MAX_BOARD'(1) << sel_row;
   assign rise_bit = DIAG_N'(1) << rise_idx;
   assign fall_bit = DIAG_N'(1) << fall_idx;
   assign sel_free = !rows_ff[sel_row] && !rise_ff[rise_idx] && !fall_ff[fall_idx];

   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      rows_in        = rows_ff;
      rise_in        = rise_ff;
      fall_in        = fall_ff;
      count_in       = count_ff;
      have_preset_in = have_preset_ff;
      preset_col_in  = preset_col_ff;
      ignored_in     = ignored_ff;
      rsp_valid_in   = 1'b0;
      stack_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               have_preset_in = req_data.preset_enable && preset_fits;
               ignored_in     = req_data.preset_enable && !preset_fits;
               preset_col_in  = req_data.preset_col;
               col_in         = '0;
               row_in         = '0;
               count_in       = '0;
               rows_in        = '0;
               rise_in        = '0;
               fall_in        = '0;
               if (req_data.preset_enable && preset_fits) begin
                  rows_in = row_bit;
                  rise_in = rise_bit;
                  fall_in = fall_bit;
               end
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            priority if (col_ff >= n_eff) begin
               count_in = count_ff + nqc_pkg::COUNT_W'(1);
               state_in = ST_BACK;
            end else if (at_preset_col) begin
               col_in = col_ff + CNT_W'(1);
               row_in = '0;
            end else if (row_ff >= n_eff) begin
               state_in = ST_BACK;
            end else if (sel_free) begin
               stack_we = 1'b1;
               rows_in  = rows_ff ^ row_bit;
               rise_in  = rise_ff ^ rise_bit;
               fall_in  = fall_ff ^ fall_bit;
               col_in   = col_ff + CNT_W'(1);
               row_in   = '0;
            end else begin
               row_in = row_ff + CNT_W'(1);
            end
         end
         ST_BACK: begin
            priority if (col_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (back_preset_col) begin
               col_in = back_col;
            end else begin
               col_in   = back_col;
               rows_in  = rows_ff ^ row_bit;
               rise_in  = rise_ff ^ rise_bit;
               fall_in  = fall_ff ^ fall_bit;
               row_in   = CNT_W'(sel_row) + CNT_W'(1);
               state_in = ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff         <= col_in;
      row_ff         <= row_in;
      rows_ff        <= rows_in;
      rise_ff        <= rise_in;
      fall_ff        <= fall_in;
      count_ff       <= count_in;
      have_preset_ff <= have_preset_in;
      preset_col_ff  <= preset_col_in;
      ignored_ff     <= ignored_in;
   end

   // row stack, undefined until written
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ff[col_ff[ROW_W-1:0]] <= row_ff[ROW_W-1:0];
      end
   end

   // configuration register
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == nqc_pkg::REG_BOARD_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= nqc_pkg::BOARD_SIZE_RESET;
      end else if (csr_write) begin
         board_size_ff <= pwdata[nqc_pkg::SIZE_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == nqc_pkg::REG_BOARD_SIZE) begin
         prdata = nqc_pkg::CSR_DATA_W'(board_size_ff);
      end
   end

   assign pready                  = 1'b1;
   assign busy                    = (state_ff != ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.solution_count = count_ff;
   assign rsp_data.preset_ignored = ignored_ff;

   // checks
   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while search still running");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start a search");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> (col_ff <= n_eff))
      else $error("column counter beyond board");

endmodule

// ===== tb/nqc_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqc_count_checker
// Watches the request, result and register channels of the n-queens counter.
// Every accepted request is solved here by a backtracking search of its own,
// against a shadow of the board size register. Each result strobe is compared
// field by field with the oldest outstanding count, and register reads are
// compared with the shadow.
// ----------------------------------------------------------------------------
module nqc_count_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  nqc_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  nqc_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [nqc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [nqc_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [nqc_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                           pready,
   output int                             mismatch_count,
   output int                             outstanding
);

   localparam int MAXB        = nqc_pkg::MAX_BOARD_DEFAULT;
   localparam int DIAG_OFFSET = MAXB - 1;

   nqc_pkg::rsp_type           counts_due[$];
   logic [nqc_pkg::SIZE_W-1:0] board_size_q;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic nqc_pkg::rsp_type count_placements(nqc_pkg::req_type item,
                                                         logic [nqc_pkg::SIZE_W-1:0] size_reg);
      int                          n;
      int                          col;
      int                          row;
      int                          first_row;
      int                          fixed_row;
      int                          fixed_col;
      logic                        fixed;
      logic                        done;
      logic                        retreat;
      logic                        stepping;
      logic [MAXB-1:0]             rows_used;
      logic [2*MAXB-2:0]           rising_used;
      logic [2*MAXB-2:0]           falling_used;
      logic [nqc_pkg::FIELD_W-1:0] row_at [MAXB];
      nqc_pkg::rsp_type            res;
      n = (size_reg > MAXB) ? MAXB : int'(size_reg);
      fixed_row = int'(item.preset_row);
      fixed_col = int'(item.preset_col);
      fixed = 1'b0;
      rows_used = '0;
      rising_used = '0;
      falling_used = '0;
      res = '0;
      for (int i = 0; i < MAXB; i++) row_at[i] = '0;
      if (item.preset_enable) begin
         if (fixed_row < n && fixed_col < n) begin
            fixed = 1'b1;
            row_at[fixed_col] = item.preset_row;
            rows_used[fixed_row] = 1'b1;
            rising_used[fixed_row + fixed_col] = 1'b1;
            falling_used[fixed_row + DIAG_OFFSET - fixed_col] = 1'b1;
         end else begin
            res.preset_ignored = 1'b1;
         end
      end
      col = 0;
      first_row = 0;
      done = 1'b0;
      while (!done) begin
         retreat = 1'b0;
         if (col >= n) begin
            res.solution_count = res.solution_count + 1'b1;
            retreat = 1'b1;
         end else if (fixed && col == fixed_col) begin
            col++;
            first_row = 0;
         end else begin
            row = first_row;
            while (row < n && (rows_used[row] || rising_used[row + col] ||
                               falling_used[row + DIAG_OFFSET - col])) row++;
            if (row < n) begin
               row_at[col] = nqc_pkg::FIELD_W'(row);
               rows_used[row] = 1'b1;
               rising_used[row + col] = 1'b1;
               falling_used[row + DIAG_OFFSET - col] = 1'b1;
               col++;
               first_row = 0;
            end else begin
               retreat = 1'b1;
            end
         end
         if (retreat) begin
            // back up to the last searched column, never onto the preset one
            stepping = 1'b1;
            while (stepping) begin
               if (col == 0) begin
                  done = 1'b1;
                  stepping = 1'b0;
               end else begin
                  col--;
                  if (!(fixed && col == fixed_col)) stepping = 1'b0;
               end
            end
            if (!done) begin
               row = int'(row_at[col]);
               rows_used[row] = 1'b0;
               rising_used[row + col] = 1'b0;
               falling_used[row + DIAG_OFFSET - col] = 1'b0;
               first_row = row + 1;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      nqc_pkg::rsp_type want;
      if (reset) begin
         board_size_q = nqc_pkg::BOARD_SIZE_RESET;
         counts_due.delete();
         mismatch_count = 0;
      end else begin
         if (start && !busy) begin
            counts_due.insert(counts_due.size(), count_placements(req_data, board_size_q));
         end
         if (rsp_valid) begin
            if (counts_due.size() == 0) begin
               report_mismatch("unexpected result beat, count", rsp_data.solution_count, 0);
            end else begin
               want = counts_due.pop_front();
               if (rsp_data.solution_count !== want.solution_count) begin
                  report_mismatch("solution_count", rsp_data.solution_count,
                                  want.solution_count);
               end
               if (rsp_data.preset_ignored !== want.preset_ignored) begin
                  report_mismatch("preset_ignored", rsp_data.preset_ignored,
                                  want.preset_ignored);
               end
            end
         end
         if (psel && penable && pready && paddr[2] == nqc_pkg::REG_BOARD_SIZE) begin
            if (pwrite) begin
               board_size_q = pwdata[nqc_pkg::SIZE_W-1:0];
            end else if (prdata !== nqc_pkg::CSR_DATA_W'(board_size_q)) begin
               report_mismatch("board_size readback", prdata, board_size_q);
            end
         end
      end
      outstanding = counts_due.size();
   end

endmodule

// ===== tb/tb_n_queens_solution_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_n_queens_solution_counter
// Drives puzzle requests and board size writes into the n-queens counter:
// a directed set over the field extremes, ignored presets and the empty and
// oversized boards, then random requests in three phases of sender idling.
// Prediction and comparison sit in nqc_count_checker; this module gives the
// verdict from its mismatch count.
// ----------------------------------------------------------------------------
module tb_n_queens_solution_counter;

   localparam int CLOCK_PERIOD     = 4;
   localparam int LIMIT_CYCLES     = 20_000_000;
   localparam int SETTLE_CYCLES    = 64;
   localparam int RANDOM_PER_PHASE = 26;
   localparam int ITEMS_PER_SIZE   = 6;
   localparam logic [nqc_pkg::CSR_ADDR_W-1:0] BOARD_SIZE_ADDR = {nqc_pkg::REG_BOARD_SIZE, 2'b00};

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   nqc_pkg::req_type               req_data;
   logic                           rsp_valid;
   nqc_pkg::rsp_type               rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [nqc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [nqc_pkg::CSR_DATA_W-1:0] pwdata;
   logic [nqc_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;
   int                             mismatch_count;
   int                             outstanding;
   int                             cycle_count = 0;
   int                             sender_idle_pct;
   int                             board_in_use;

   n_queens_solution_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   nqc_count_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_access(input logic write_en,
                             input logic [nqc_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= BOARD_SIZE_ADDR;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   task automatic set_board(input int size);
      wait_drained();
      csr_access(1'b1, nqc_pkg::CSR_DATA_W'(size));
      csr_access(1'b0, '0);
      board_in_use = (size > nqc_pkg::MAX_BOARD_DEFAULT) ? nqc_pkg::MAX_BOARD_DEFAULT : size;
   endtask

   task automatic send_request(input nqc_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      // busy only moves on a rising edge, so low here means a beat at the next one
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic int pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return 0;
      if (roll < 12) return 1;
      if (roll < 72) return $urandom_range(6, 2);
      if (roll < 91) return 7;
      return 8;
   endfunction

   function automatic nqc_pkg::req_type random_request(int n);
      int               roll;
      nqc_pkg::req_type item;
      roll = $urandom_range(99);
      item.preset_enable = (roll < 75);
      if (roll < 60 && n > 0) begin
         item.preset_row = nqc_pkg::FIELD_W'($urandom_range(n - 1));
         item.preset_col = nqc_pkg::FIELD_W'($urandom_range(n - 1));
      end else begin
         item.preset_row = nqc_pkg::FIELD_W'($urandom_range((1 << nqc_pkg::FIELD_W) - 1));
         item.preset_col = nqc_pkg::FIELD_W'($urandom_range((1 << nqc_pkg::FIELD_W) - 1));
      end
      return item;
   endfunction

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      sender_idle_pct = 6;
      board_in_use = int'(nqc_pkg::BOARD_SIZE_RESET);
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // read back the reset board size, then field extremes and presets off the board
      csr_access(1'b0, '0);
      send_request({1'b0, 4'd0, 4'd0});
      send_request({1'b0, 4'd15, 4'd15});
      send_request({1'b1, 4'd0, 4'd0});
      send_request({1'b1, 4'd7, 4'd7});
      send_request({1'b1, 4'd15, 4'd15});
      send_request({1'b1, 4'd3, 4'd8});
      send_request({1'b1, 4'd8, 4'd3});

      // empty board
      set_board(0);
      send_request({1'b0, 4'd0, 4'd0});
      send_request({1'b1, 4'd0, 4'd0});
      send_request({1'b0, 4'd15, 4'd15});

      set_board(1);
      send_request({1'b1, 4'd0, 4'd0});
      send_request({1'b1, 4'd1, 4'd0});
      send_request({1'b0, 4'd10, 4'd5});

      set_board(4);
      send_request({1'b0, 4'd0, 4'd0});
      send_request({1'b1, 4'd1, 4'd0});
      send_request({1'b1, 4'd0, 4'd0});
      send_request({1'b1, 4'd3, 4'd3});
      send_request({1'b1, 4'd2, 4'd1});

      set_board(9);
      send_request({1'b1, 4'd4, 4'd4});

      // full and saturating sizes: register only, a search there is far too long
      set_board(nqc_pkg::MAX_BOARD_DEFAULT);
      set_board((1 << nqc_pkg::SIZE_W) - 1);

      set_board(2);
      send_request({1'b0, 4'd0, 4'd0});
      send_request({1'b1, 4'd1, 4'd1});
      send_request({1'b1, 4'd2, 4'd0});

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 49 : 0;
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (k % ITEMS_PER_SIZE == 0) set_board(pick_size());
            send_request(random_request(board_in_use));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/nqc_pkg.sv
rtl/n_queens_solution_counter.sv
tb/nqc_count_checker.sv
tb/tb_n_queens_solution_counter.sv
